// File: hdl/rbc_pkg.sv
// Shared types, constants and helper functions for the region binarizer
// and 4x2 cell classifier. No dependencies.
package rbc_pkg;

  localparam int unsigned FRAME_DIM = 256;

  localparam int COORD_W    = 8;
  localparam int COLOR_W    = 8;
  localparam int COUNT_W    = 14;
  localparam int NUM_CELLS  = 8;
  localparam int CELL_IDX_W = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int CLASS_W    = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_MIN     = 3'd0,
    REG_Y_MIN     = 3'd1,
    REG_X_MAX     = 3'd2,
    REG_Y_MAX     = 3'd3,
    REG_THRESHOLD = 3'd4
  } cfg_reg_t;

  localparam logic [COORD_W-1:0] RST_X_MIN     = 8'd32;
  localparam logic [COORD_W-1:0] RST_Y_MIN     = 8'd160;
  localparam logic [COORD_W-1:0] RST_X_MAX     = 8'd96;
  localparam logic [COORD_W-1:0] RST_Y_MAX     = 8'd224;
  localparam logic [COLOR_W-1:0] RST_THRESHOLD = 8'd128;

  typedef enum logic [CLASS_W-1:0] {
    PIECE_NONE = 3'd0,
    PIECE_O    = 3'd1,
    PIECE_I    = 3'd2,
    PIECE_S    = 3'd3,
    PIECE_Z    = 3'd4,
    PIECE_L    = 3'd5,
    PIECE_J    = 3'd6,
    PIECE_T    = 3'd7
  } piece_t;

  // Cell pattern of each piece, indexed by class code
  localparam logic [NUM_CELLS-1:0] PIECE_PATTERN [NUM_CELLS] = '{
    8'h00, 8'h66, 8'h0F, 8'h6C, 8'hC6, 8'h2E, 8'h8E, 8'h4E
  };

  // Region geometry derived from the configuration registers
  typedef struct packed {
    logic [COORD_W-1:0] xmin;
    logic [COORD_W-1:0] xmax;
    logic [COORD_W-1:0] ymin;
    logic [COORD_W-1:0] ymax;
    logic [6:0]         cw;
    logic [7:0]         cw2;
    logic [8:0]         cw3;
    logic [8:0]         cw4;
    logic [7:0]         ch;
    logic [8:0]         ch2;
    logic [12:0]        half;
    logic [COLOR_W-1:0] thresh;
    logic               active;
  } geom_t;

  // One located pixel on its way to the counters
  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic [CELL_IDX_W-1:0] idx;
    logic                  last;
  } cell_hit_t;

  function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] v);
    logic [COORD_W-1:0] res;
    res = v;
    if (32'(v) > FRAME_DIM - 1) begin
      res = COORD_W'(FRAME_DIM - 1);
    end
    return res;
  endfunction

  function automatic piece_t classify(logic [NUM_CELLS-1:0] bits);
    piece_t cls;
    cls = PIECE_NONE;
    for (int k = NUM_CELLS - 1; k >= 1; k--) begin
      if (bits == PIECE_PATTERN[k]) begin
        cls = piece_t'(CLASS_W'(k));
      end
    end
    return cls;
  endfunction

endpackage

// File: hdl/rbc_pixel_if.sv
// Pixel input channel: valid/ready handshake with coordinates and BGR.
// Depends on rbc_pkg.
interface rbc_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [rbc_pkg::COORD_W-1:0]  pixel_x;
  logic [rbc_pkg::COORD_W-1:0]  pixel_y;
  logic [rbc_pkg::COLOR_W-1:0]  blue;
  logic [rbc_pkg::COLOR_W-1:0]  green;
  logic [rbc_pkg::COLOR_W-1:0]  red;
  logic                         frame_end;

  modport source (output valid, pixel_x, pixel_y, blue, green, red, frame_end,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, blue, green, red, frame_end,
                output ready);
endinterface

// File: hdl/rbc_result_if.sv
// Result channel: valid/ready handshake with piece class and cell bits.
// Depends on rbc_pkg.
interface rbc_result_if;
  logic                           valid;
  logic                           ready;
  logic [rbc_pkg::CLASS_W-1:0]    piece_class;
  logic [rbc_pkg::NUM_CELLS-1:0]  cell_bits;

  modport source (output valid, piece_class, cell_bits, input ready);
  modport sink (input valid, piece_class, cell_bits, output ready);
endinterface

// File: hdl/rbc_cfg_if.sv
// Configuration write channel: valid/ready with register index and data.
// Depends on rbc_pkg.
interface rbc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rbc_pkg::CFG_IDX_W-1:0]   index;
  logic [rbc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/region_binarize_cell_classifier_unit.sv
// Top level of the region binarizer and 4x2 cell classifier.
// Depends on rbc_pkg, the three channel interfaces, rbc_cfg_regs,
// rbc_locate and rbc_accum.

// Takes one pixel word per clock. A pixel passes an input register, where
// its cell and white test are worked out, then a hit register that feeds
// the eight cell counters; a frame-end word's result is written to the output
// register when the counters take that word. Input ready drops only
// while a frame-end word sits at the counters and the previous result has
// not been taken; other pixels keep flowing while a result waits. Register
// writes take effect at once and are meant for idle periods only.
module region_binarize_cell_classifier_unit (
  input  logic         clk,
  input  logic         rst_n,
  rbc_pixel_if.sink    in_pix,
  rbc_result_if.source out_res,
  rbc_cfg_if.sink      cfg_wr
);

  rbc_pkg::geom_t     geom;
  rbc_pkg::cell_hit_t hit;
  logic               b_move;

  rbc_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_wr),
    .geom  (geom)
  );

  rbc_locate u_locate (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (in_pix),
    .geom   (geom),
    .b_move (b_move),
    .hit    (hit)
  );

  rbc_accum u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .hit     (hit),
    .geom    (geom),
    .b_move  (b_move),
    .out_res (out_res)
  );

`ifndef SYNTHESIS
  // Input backpressure only comes from a blocked frame-end word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_pix.ready |-> (hit.valid && hit.last && out_res.valid && !out_res.ready))
    else $error("input stalled without a blocked frame-end word");

  // A new result follows a frame-end word at the counters
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> $past(hit.valid && hit.last))
    else $error("result raised without a frame-end word");

  // An empty or too small region reports no cells
  a_empty_region: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && !geom.active) |-> (out_res.cell_bits == '0))
    else $error("cell bits set for an empty region");
`endif

endmodule

// File: hdl/rbc_cfg_regs.sv
// Configuration registers and the region geometry derived from them.
// Depends on rbc_pkg and rbc_cfg_if.
module rbc_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  rbc_cfg_if.sink        cfg,
  output rbc_pkg::geom_t geom
);

  logic [rbc_pkg::COORD_W-1:0] x_min_r, x_min_nxt;
  logic [rbc_pkg::COORD_W-1:0] y_min_r, y_min_nxt;
  logic [rbc_pkg::COORD_W-1:0] x_max_r, x_max_nxt;
  logic [rbc_pkg::COORD_W-1:0] y_max_r, y_max_nxt;
  logic [rbc_pkg::COLOR_W-1:0] thresh_r, thresh_nxt;

  logic [rbc_pkg::COORD_W-1:0] xmin, xmax, ymin, ymax;
  logic [8:0]                  span_x, span_y;
  logic [6:0]                  cw;
  logic [7:0]                  ch;
  logic [14:0]                 area;

  assign cfg.ready = 1'b1;

  always_comb begin
    x_min_nxt  = x_min_r;
    y_min_nxt  = y_min_r;
    x_max_nxt  = x_max_r;
    y_max_nxt  = y_max_r;
    thresh_nxt = thresh_r;
    if (cfg.valid) begin
      unique case (cfg.index)
        rbc_pkg::REG_X_MIN:     x_min_nxt  = cfg.data;
        rbc_pkg::REG_Y_MIN:     y_min_nxt  = cfg.data;
        rbc_pkg::REG_X_MAX:     x_max_nxt  = cfg.data;
        rbc_pkg::REG_Y_MAX:     y_max_nxt  = cfg.data;
        rbc_pkg::REG_THRESHOLD: thresh_nxt = cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r  <= rbc_pkg::RST_X_MIN;
      y_min_r  <= rbc_pkg::RST_Y_MIN;
      x_max_r  <= rbc_pkg::RST_X_MAX;
      y_max_r  <= rbc_pkg::RST_Y_MAX;
      thresh_r <= rbc_pkg::RST_THRESHOLD;
    end else begin
      x_min_r  <= x_min_nxt;
      y_min_r  <= y_min_nxt;
      x_max_r  <= x_max_nxt;
      y_max_r  <= y_max_nxt;
      thresh_r <= thresh_nxt;
    end
  end

  always_comb begin
    xmin = rbc_pkg::clamp_coord(x_min_r);
    ymin = rbc_pkg::clamp_coord(y_min_r);
    xmax = rbc_pkg::clamp_coord(x_max_r);
    ymax = rbc_pkg::clamp_coord(y_max_r);
    // Inverted range gives an empty span
    span_x = (xmax >= xmin) ? ({1'b0, xmax} - {1'b0, xmin} + 9'd1) : 9'd0;
    span_y = (ymax >= ymin) ? ({1'b0, ymax} - {1'b0, ymin} + 9'd1) : 9'd0;
    cw   = span_x[8:2];
    ch   = span_y[8:1];
    area = 15'(cw) * 15'(ch);

    geom.xmin   = xmin;
    geom.xmax   = xmax;
    geom.ymin   = ymin;
    geom.ymax   = ymax;
    geom.cw     = cw;
    geom.cw2    = {cw, 1'b0};
    geom.cw4    = {cw, 2'b00};
    geom.cw3    = {2'b00, cw} + {1'b0, cw, 1'b0};
    geom.ch     = ch;
    geom.ch2    = {ch, 1'b0};
    geom.half   = area[13:1];
    geom.thresh = thresh_r;
    geom.active = (cw != 7'd0) && (ch != 8'd0);
  end

endmodule

// File: hdl/rbc_locate.sv
// Input register plus cell lookup and white test; registers the cell hit.
// Depends on rbc_pkg and rbc_pixel_if.
module rbc_locate (
  input  logic               clk,
  input  logic               rst_n,
  rbc_pixel_if.sink          in_pix,
  input  rbc_pkg::geom_t     geom,
  input  logic               b_move,
  output rbc_pkg::cell_hit_t hit
);

  logic                        a_valid_r, a_valid_nxt;
  logic [rbc_pkg::COORD_W-1:0] a_x_r, a_y_r;
  logic [rbc_pkg::COLOR_W-1:0] a_b_r, a_g_r, a_r_r;
  logic                        a_last_r;
  logic                        load;

  rbc_pkg::cell_hit_t hit_r, hit_nxt;

  logic [rbc_pkg::COORD_W-1:0] dx, dy;
  logic [8:0]                  dx9, dy9;
  logic                        in_x, in_y;
  logic                        col_ok, row_ok;
  logic [1:0]                  col;
  logic                        row;
  logic [9:0]                  sum;
  logic                        white;

  assign in_pix.ready = !a_valid_r || b_move;
  assign load         = in_pix.valid && in_pix.ready;
  assign a_valid_nxt  = in_pix.ready ? in_pix.valid : a_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_x_r    <= in_pix.pixel_x;
      a_y_r    <= in_pix.pixel_y;
      a_b_r    <= in_pix.blue;
      a_g_r    <= in_pix.green;
      a_r_r    <= in_pix.red;
      a_last_r <= in_pix.frame_end;
    end
  end

  always_comb begin
    in_x = (a_x_r >= geom.xmin) && (a_x_r <= geom.xmax) &&
           (32'(a_x_r) < rbc_pkg::FRAME_DIM);
    in_y = (a_y_r >= geom.ymin) && (a_y_r <= geom.ymax) &&
           (32'(a_y_r) < rbc_pkg::FRAME_DIM);
    dx  = a_x_r - geom.xmin;
    dy  = a_y_r - geom.ymin;
    dx9 = {1'b0, dx};
    dy9 = {1'b0, dy};

    // Column by comparing the offset against multiples of the cell width;
    // leftover columns past four full cells fall out
    col_ok = 1'b1;
    if (dx9 < {2'b00, geom.cw}) begin
      col = 2'd0;
    end else if (dx9 < {1'b0, geom.cw2}) begin
      col = 2'd1;
    end else if (dx9 < geom.cw3) begin
      col = 2'd2;
    end else if (dx9 < geom.cw4) begin
      col = 2'd3;
    end else begin
      col    = 2'd0;
      col_ok = 1'b0;
    end

    row_ok = 1'b1;
    if (dy9 < {1'b0, geom.ch}) begin
      row = 1'b0;
    end else if (dy9 < geom.ch2) begin
      row = 1'b1;
    end else begin
      row    = 1'b0;
      row_ok = 1'b0;
    end

    sum   = 10'(a_r_r) + 10'(a_g_r) + 10'(a_b_r);
    white = sum[9:2] >= geom.thresh;

    hit_nxt.valid = a_valid_r;
    hit_nxt.hit   = geom.active && in_x && in_y && col_ok && row_ok && white;
    // Top row lands in the upper nibble
    hit_nxt.idx   = {!row, col};
    hit_nxt.last  = a_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= '0;
    end else if (b_move) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

// File: hdl/rbc_accum.sv
// Per-cell white counters, majority test, piece lookup and result register.
// Depends on rbc_pkg and rbc_result_if.
module rbc_accum (
  input  logic               clk,
  input  logic               rst_n,
  input  rbc_pkg::cell_hit_t hit,
  input  rbc_pkg::geom_t     geom,
  output logic               b_move,
  rbc_result_if.source       out_res
);

  logic [rbc_pkg::COUNT_W-1:0]   count_r   [rbc_pkg::NUM_CELLS];
  logic [rbc_pkg::COUNT_W-1:0]   count_nxt [rbc_pkg::NUM_CELLS];
  logic [rbc_pkg::NUM_CELLS-1:0] inc;
  logic [rbc_pkg::NUM_CELLS-1:0] bits_nxt;
  logic [rbc_pkg::NUM_CELLS-1:0] bits_r;
  rbc_pkg::piece_t               class_r;
  logic                          out_valid_r, out_valid_nxt;
  logic                          take, emit;
  logic [rbc_pkg::COUNT_W-1:0]   half_w;

  // Hold only a frame-end word whose result slot is still occupied
  assign b_move = !(hit.valid && hit.last && out_valid_r && !out_res.ready);
  assign take   = hit.valid && b_move;
  assign emit   = take && hit.last;
  assign half_w = {1'b0, geom.half};

  always_comb begin
    for (int k = 0; k < rbc_pkg::NUM_CELLS; k++) begin
      inc[k] = hit.hit && (hit.idx == rbc_pkg::CELL_IDX_W'(k)) &&
               (count_r[k] != rbc_pkg::COUNT_MAX);
      count_nxt[k] = count_r[k];
      if (take) begin
        if (hit.last) begin
          count_nxt[k] = '0;
        end else if (inc[k]) begin
          count_nxt[k] = count_r[k] + 1'b1;
        end
      end
      // Majority on the count including this word's increment
      bits_nxt[k] = geom.active &&
                    ((count_r[k] > half_w) || (inc[k] && (count_r[k] == half_w)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < rbc_pkg::NUM_CELLS; k++) begin
        count_r[k] <= '0;
      end
    end else begin
      count_r <= count_nxt;
    end
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_res.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      bits_r  <= bits_nxt;
      class_r <= rbc_pkg::classify(bits_nxt);
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.cell_bits   = bits_r;
  assign out_res.piece_class = class_r;

endmodule

// File: sim/tb.sv
// Testbench for region_binarize_cell_classifier_unit: drives pixel words and
// register writes, predicts each frame's piece class and cell bits.
// Depends on rbc_pkg, the three channel interfaces and the block itself.
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_WORDS = 110;

  typedef struct packed {
    logic [rbc_pkg::COORD_W-1:0] x;
    logic [rbc_pkg::COORD_W-1:0] y;
    logic [rbc_pkg::COLOR_W-1:0] b;
    logic [rbc_pkg::COLOR_W-1:0] g;
    logic [rbc_pkg::COLOR_W-1:0] r;
    logic                        fe;
  } pixel_word_t;

  typedef struct packed {
    rbc_pkg::piece_t                cls;
    logic [rbc_pkg::NUM_CELLS-1:0]  bits;
  } piece_result_t;

  // Tracks the cell tallies and the piece results still owed by the block
  class piece_scoreboard;
    logic [rbc_pkg::CFG_DATA_W-1:0] x_lo, y_lo, x_hi, y_hi, level;
    logic [rbc_pkg::COUNT_W-1:0]    tally [rbc_pkg::NUM_CELLS];
    piece_result_t                  pending_pieces [$];
    int                             mismatches;

    function new();
      x_lo = rbc_pkg::RST_X_MIN;
      y_lo = rbc_pkg::RST_Y_MIN;
      x_hi = rbc_pkg::RST_X_MAX;
      y_hi = rbc_pkg::RST_Y_MAX;
      level = rbc_pkg::RST_THRESHOLD;
      mismatches = 0;
      foreach (tally[k]) tally[k] = '0;
    endfunction

    function void write_reg(rbc_pkg::cfg_reg_t idx, logic [rbc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        rbc_pkg::REG_X_MIN:     x_lo = val;
        rbc_pkg::REG_Y_MIN:     y_lo = val;
        rbc_pkg::REG_X_MAX:     x_hi = val;
        rbc_pkg::REG_Y_MAX:     y_hi = val;
        rbc_pkg::REG_THRESHOLD: level = val;
        default: ;
      endcase
    endfunction

    function int unsigned clip_dim(int unsigned v);
      return (v > rbc_pkg::FRAME_DIM - 1) ? rbc_pkg::FRAME_DIM - 1 : v;
    endfunction

    function void note_pixel(pixel_word_t p);
      int unsigned xmin, ymin, xmax, ymax, cw, ch, col, row, quarter, half, idx;
      logic [rbc_pkg::NUM_CELLS-1:0] bits;
      rbc_pkg::piece_t cls;
      piece_result_t res;
      xmin = clip_dim(x_lo);
      ymin = clip_dim(y_lo);
      xmax = clip_dim(x_hi);
      ymax = clip_dim(y_hi);
      cw = (xmax >= xmin) ? (xmax - xmin + 1) / 4 : 0;
      ch = (ymax >= ymin) ? (ymax - ymin + 1) / 2 : 0;
      if (cw != 0 && ch != 0 && p.x < rbc_pkg::FRAME_DIM && p.y < rbc_pkg::FRAME_DIM &&
          p.x >= xmin && p.x <= xmax && p.y >= ymin && p.y <= ymax) begin
        col = (p.x - xmin) / cw;
        row = (p.y - ymin) / ch;
        quarter = (int'(p.r) + int'(p.g) + int'(p.b)) >> 2;
        if (col < 4 && row < 2 && quarter >= level) begin
          idx = 4 * (1 - row) + col;
          // saturate instead of wrapping
          if (~&tally[idx]) tally[idx] = tally[idx] + 1'b1;
        end
      end
      if (!p.fe) return;
      half = (cw * ch) / 2;
      bits = '0;
      for (int k = 0; k < rbc_pkg::NUM_CELLS; k++) begin
        if (cw != 0 && ch != 0 && tally[k] > half) bits[k] = 1'b1;
      end
      cls = rbc_pkg::PIECE_NONE;
      for (int k = 1; k < rbc_pkg::NUM_CELLS; k++) begin
        if (cls == rbc_pkg::PIECE_NONE && bits == rbc_pkg::PIECE_PATTERN[k])
          cls = rbc_pkg::piece_t'(3'(k));
      end
      res.cls = cls;
      res.bits = bits;
      pending_pieces.push_back(res);
      foreach (tally[k]) tally[k] = '0;
    endfunction

    function void note_miss(string msg);
      if (mismatches < 10) $display("mismatch: %s", msg);
      mismatches++;
    endfunction

    function void check_piece(logic [rbc_pkg::CLASS_W-1:0] got_cls,
                              logic [rbc_pkg::NUM_CELLS-1:0] got_bits);
      piece_result_t want;
      if (pending_pieces.size() == 0) begin
        note_miss($sformatf("unexpected word class %0d bits %02h", got_cls, got_bits));
        return;
      end
      want = pending_pieces.pop_front();
      if (want.cls != got_cls)
        note_miss($sformatf("class expected %0d actual %0d", want.cls, got_cls));
      if (want.bits != got_bits)
        note_miss($sformatf("cell bits expected %02h actual %02h", want.bits, got_bits));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  rbc_pixel_if  pix_if ();
  rbc_result_if res_if ();
  rbc_cfg_if    cfg_if ();

  region_binarize_cell_classifier_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_if),
    .out_res(res_if),
    .cfg_wr (cfg_if)
  );

  piece_scoreboard board;

  int cycle_count = 0;
  int words_sent = 0;
  bit calm = 1'b0;
  bit tx_gaps = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rx_gap = 0;
  int rx_mode_left = 0;
  bit rx_busy = 1'b0;
  int cur_xmin, cur_ymin, cur_xmax, cur_ymax, cur_thr;

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts, quiet stretches, and one long hold-off
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode_left <= $urandom_range(40, 300);
      rx_busy <= ($urandom_range(0, 2) != 0);
    end else begin
      rx_mode_left <= rx_mode_left - 1;
    end
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= 300;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else if (calm) begin
      res_if.ready <= 1'b1;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      res_if.ready <= 1'b0;
    end else if (rx_busy && $urandom_range(0, 5) == 0) begin
      rx_gap <= $urandom_range(0, 9);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready)
      board.check_piece(res_if.piece_class, res_if.cell_bits);
  end

  function automatic pixel_word_t mk_pixel(int x, int y, int b, int g, int r, bit fe);
    pixel_word_t p;
    p.x = 8'(x);
    p.y = 8'(y);
    p.b = 8'(b);
    p.g = 8'(g);
    p.r = 8'(r);
    p.fe = fe;
    return p;
  endfunction

  task automatic send_pixel(pixel_word_t p);
    int gap;
    if (!calm && tx_gaps && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel_x <= p.x;
    pix_if.pixel_y <= p.y;
    pix_if.blue <= p.b;
    pix_if.green <= p.g;
    pix_if.red <= p.r;
    pix_if.frame_end <= p.fe;
    do @(posedge clk); while (!pix_if.ready);
    board.note_pixel(p);
    words_sent++;
  endtask

  // Hold input low until every owed result is in, then let the pipeline empty
  task automatic drain();
    pix_if.valid <= 1'b0;
    while (board.pending_pieces.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_region(int xlo, int ylo, int xhi, int yhi, int thr);
    rbc_pkg::cfg_reg_t              regs [5];
    logic [rbc_pkg::CFG_DATA_W-1:0] vals [5];
    regs = '{rbc_pkg::REG_X_MIN, rbc_pkg::REG_Y_MIN, rbc_pkg::REG_X_MAX,
             rbc_pkg::REG_Y_MAX, rbc_pkg::REG_THRESHOLD};
    vals = '{8'(xlo), 8'(ylo), 8'(xhi), 8'(yhi), 8'(thr)};
    drain();
    cur_xmin = xlo;
    cur_ymin = ylo;
    cur_xmax = xhi;
    cur_ymax = yhi;
    cur_thr = thr;
    for (int i = 0; i < 5; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= regs[i];
      cfg_if.data <= vals[i];
      do @(posedge clk); while (!cfg_if.ready);
      board.write_reg(regs[i], vals[i]);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Raster over the region (sometimes with a one-pixel border), painting a
  // target cell pattern with a little noise; frame end on the last word.
  task automatic send_shape_frame();
    logic [rbc_pkg::NUM_CELLS-1:0] target;
    int cw, ch, border, x0, x1, y0, y1, col, row, lo, v, pick;
    bit white, in_cell;
    pixel_word_t p;
    pick = $urandom_range(0, 9);
    target = (pick < rbc_pkg::NUM_CELLS) ? rbc_pkg::PIECE_PATTERN[pick] :
                                           8'($urandom_range(0, 255));
    cw = (cur_xmax - cur_xmin + 1) / 4;
    ch = (cur_ymax - cur_ymin + 1) / 2;
    border = $urandom_range(0, 1);
    x0 = (cur_xmin - border < 0) ? 0 : cur_xmin - border;
    y0 = (cur_ymin - border < 0) ? 0 : cur_ymin - border;
    x1 = (cur_xmax + border > 255) ? 255 : cur_xmax + border;
    y1 = (cur_ymax + border > 255) ? 255 : cur_ymax + border;
    lo = (4 * cur_thr + 2) / 3;
    if (lo > 255) lo = 255;
    tx_gaps = ($urandom_range(0, 2) != 0);
    for (int yy = y0; yy <= y1; yy++) begin
      for (int xx = x0; xx <= x1; xx++) begin
        // drop a word now and then, never the frame end
        if ((yy != y1 || xx != x1) && $urandom_range(0, 15) == 0) continue;
        in_cell = 1'b0;
        white = 1'b0;
        if (cw != 0 && ch != 0 && xx >= cur_xmin && xx <= cur_xmax &&
            yy >= cur_ymin && yy <= cur_ymax) begin
          col = (xx - cur_xmin) / cw;
          row = (yy - cur_ymin) / ch;
          if (col < 4 && row < 2) begin
            in_cell = 1'b1;
            white = target[4 * (1 - row) + col] ^ ($urandom_range(0, 7) == 0);
          end
        end
        if (!in_cell) begin
          p = mk_pixel(xx, yy, $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), (yy == y1 && xx == x1));
        end else if (white) begin
          v = $urandom_range(lo, 255);
          p = mk_pixel(xx, yy, v, v, $urandom_range(v, 255), (yy == y1 && xx == x1));
        end else begin
          v = (lo == 0) ? 0 : $urandom_range(0, lo - 1);
          p = mk_pixel(xx, yy, v, v, $urandom_range(0, v), (yy == y1 && xx == x1));
        end
        send_pixel(p);
      end
    end
  endtask

  task automatic send_noise_frame();
    int len, xlo, xhi, ylo, yhi, x, y;
    len = $urandom_range(1, 40);
    xlo = (cur_xmin < cur_xmax) ? cur_xmin : cur_xmax;
    xhi = (cur_xmin < cur_xmax) ? cur_xmax : cur_xmin;
    ylo = (cur_ymin < cur_ymax) ? cur_ymin : cur_ymax;
    yhi = (cur_ymin < cur_ymax) ? cur_ymax : cur_ymin;
    tx_gaps = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < len; i++) begin
      x = $urandom_range(0, 1) ? $urandom_range(xlo, xhi) : $urandom_range(0, 255);
      y = $urandom_range(0, 1) ? $urandom_range(ylo, yhi) : $urandom_range(0, 255);
      send_pixel(mk_pixel(x, y, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), (i == len - 1)));
    end
  endtask

  initial begin
    int w, h, xmin, ymin, thr, phase_start, spx, spy;
    board = new();
    rst_n <= 1'b0;
    pix_if.valid <= 1'b0;
    pix_if.pixel_x <= '0;
    pix_if.pixel_y <= '0;
    pix_if.blue <= '0;
    pix_if.green <= '0;
    pix_if.red <= '0;
    pix_if.frame_end <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= rbc_pkg::REG_X_MIN;
    cfg_if.data <= '0;
    cur_xmin = rbc_pkg::RST_X_MIN;
    cur_ymin = rbc_pkg::RST_Y_MIN;
    cur_xmax = rbc_pkg::RST_X_MAX;
    cur_ymax = rbc_pkg::RST_Y_MAX;
    cur_thr = rbc_pkg::RST_THRESHOLD;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Reset region: frame corners, leftover column/row, threshold boundary
    send_pixel(mk_pixel(0, 0, 0, 0, 0, 0));
    send_pixel(mk_pixel(255, 255, 255, 255, 255, 0));
    send_pixel(mk_pixel(32, 160, 255, 255, 255, 0));
    send_pixel(mk_pixel(95, 223, 255, 255, 255, 0));
    send_pixel(mk_pixel(96, 224, 255, 255, 255, 0));
    send_pixel(mk_pixel(31, 159, 255, 255, 255, 0));
    send_pixel(mk_pixel(40, 170, 170, 171, 171, 0));
    send_pixel(mk_pixel(41, 170, 170, 170, 171, 0));
    send_pixel(mk_pixel(0, 0, 0, 0, 0, 1));
    send_pixel(mk_pixel(0, 0, 0, 0, 0, 1));

    // One-pixel cells: O, then T, then I
    apply_region(0, 0, 3, 1, 128);
    send_pixel(mk_pixel(1, 0, 200, 200, 200, 0));
    send_pixel(mk_pixel(2, 0, 200, 200, 200, 0));
    send_pixel(mk_pixel(1, 1, 200, 200, 200, 0));
    send_pixel(mk_pixel(2, 1, 200, 200, 200, 0));
    send_pixel(mk_pixel(3, 1, 10, 10, 10, 1));
    send_pixel(mk_pixel(1, 1, 255, 255, 255, 0));
    send_pixel(mk_pixel(2, 1, 255, 255, 255, 0));
    send_pixel(mk_pixel(3, 1, 255, 255, 255, 0));
    send_pixel(mk_pixel(2, 0, 255, 255, 255, 1));
    send_pixel(mk_pixel(0, 1, 180, 180, 180, 0));
    send_pixel(mk_pixel(1, 1, 180, 180, 180, 0));
    send_pixel(mk_pixel(2, 1, 180, 180, 180, 0));
    send_pixel(mk_pixel(3, 1, 180, 180, 180, 1));

    for (int ph = 0; ph < 13; ph++) begin
      // Last stretch runs with no idling on either side
      if (ph == 12) calm <= 1'b1;
      w = $urandom_range(4, 12);
      h = $urandom_range(2, 6);
      xmin = $urandom_range(0, 256 - w);
      ymin = $urandom_range(0, 256 - h);
      thr = $urandom_range(1, 191);
      case (ph)
        0: apply_region(xmin, ymin, xmin + w - 1, ymin + h - 1, 0);
        1: apply_region(xmin, ymin, xmin + w - 1, ymin + h - 1, 255);
        2: apply_region(200, ymin, 10, ymin + h - 1, thr);
        3: apply_region(0, 255, 255, 0, thr);
        4: apply_region(50, 10, 52, 20, thr);
        5: apply_region(0, 7, 15, 7, thr);
        6: apply_region(0, 0, 255, 255, 191);
        7: apply_region(252, 254, 255, 255, thr);
        8: apply_region(0, 0, 7, 3, thr);
        default: apply_region(xmin, ymin, xmin + w - 1, ymin + h - 1, thr);
      endcase
      if (ph == 8) begin
        // Long result hold-off while short frames keep coming
        hold_requests <= hold_requests + 1;
        tx_gaps = 1'b0;
        for (int i = 0; i < 12; i++) begin
          send_pixel(mk_pixel($urandom_range(0, 7), $urandom_range(0, 3), 255, 255, 255, 0));
          send_pixel(mk_pixel($urandom_range(0, 7), $urandom_range(0, 3), 255, 255, 255, 1));
        end
      end
      spx = (cur_xmax >= cur_xmin) ? cur_xmax - cur_xmin + 1 : 0;
      spy = (cur_ymax >= cur_ymin) ? cur_ymax - cur_ymin + 1 : 0;
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        if (spx * spy > 0 && spx * spy <= 160 && $urandom_range(0, 3) != 0)
          send_shape_frame();
        else
          send_noise_frame();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (board.mismatches == 0 && board.pending_pieces.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
